// ----- design/fstp_pkg.sv -----
// Package for the FSK serial tape port: beat payload types, register indexes,
// mode codes and the shift rate tables.
// Depends on nothing; used by fsk_serial_tape_port.
package fstp_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 7;
	localparam int unsigned CNT_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_FSK_SETUP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLOCK_SETUP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IRQ_MASK = 2'd2;

	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_LOAD = 2'd1;
	localparam logic [1:0] MODE_FLAGS = 2'd2;
	localparam logic [1:0] MODE_NONE = 2'd3;

	localparam logic [CNT_W-1:0] CNT_SAT = 13'd8191;
	localparam logic [CNT_W-1:0] HALF_BASE = 13'd32;
	localparam logic [15:0] SHIFT_RESET = 16'hffff;
	localparam logic [3:0] BITS_MAX = 4'd15;
	localparam logic [3:0] BITS_DONE = 4'd9;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data;
		logic       irq_in;
		logic       pb7_in;
	} fsk_in_t;

	typedef struct packed {
		logic       serial_out;
		logic       clock_out;
		logic       interrupt;
		logic [3:0] flags;
	} fsk_out_t;

	function automatic logic [CNT_W-1:0] rate_period(input logic [2:0] sel);
		logic [CNT_W-1:0] r;
		case (sel)
			3'd0: r = 13'd1;
			3'd1: r = 13'd2;
			3'd2: r = 13'd128;
			3'd3: r = 13'd256;
			3'd4: r = 13'd512;
			3'd5: r = 13'd1024;
			3'd6: r = 13'd2048;
			default: r = 13'd4096;
		endcase
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] rate_tenth(input logic [2:0] sel);
		logic [CNT_W-1:0] r;
		case (sel)
			3'd0: r = 13'd0;
			3'd1: r = 13'd0;
			3'd2: r = 13'd12;
			3'd3: r = 13'd25;
			3'd4: r = 13'd51;
			3'd5: r = 13'd102;
			3'd6: r = 13'd204;
			default: r = 13'd409;
		endcase
		return r;
	endfunction

endpackage

// ----- design/fsk_serial_tape_port.sv -----
// Top level of the FSK serial tape port: input register, tick/load/flag logic
// and the result register.
// Depends on fstp_pkg.

// The port accepts one beat per clock unless a full result register is stalled by
// the output side. Each accepted beat waits in the input register; its result is
// loaded into the result register once that register is empty or the output side is
// ready. Every beat goes through the input register, then counter increment,
// compare and mask logic that updates the port state and fills the result register;
// the state loop closes in that logic, so back-to-back beats see each other's
// effects in order. Configuration writes are registered and apply to later beats.
module fsk_serial_tape_port import fstp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  fsk_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output fsk_out_t              out_data
);

	logic [6:0] fsk_setup_q;
	logic [4:0] clock_setup_q;
	logic [1:0] irq_mask_q;

	logic       valid_s1;
	fsk_in_t    item_s1;
	logic       out_valid_q;
	fsk_out_t   out_q;

	logic [15:0]      shift_word_q;
	logic [CNT_W-1:0] pulse_elapsed_q;
	logic [CNT_W-1:0] clock_elapsed_q;
	logic [3:0]       bits_sent_q;
	logic             serial_level_q;
	logic             clock_level_q;
	logic [3:0]       flag_bits_q;

	logic             advance;
	logic             consume;

	logic [15:0]      shift_word_d;
	logic [CNT_W-1:0] pulse_elapsed_d;
	logic [CNT_W-1:0] clock_elapsed_d;
	logic [3:0]       bits_sent_d;
	logic             serial_level_d;
	logic             clock_level_d;
	logic [3:0]       flag_bits_d;
	logic             intr;

	assign advance = !out_valid_q || out_ready;
	assign consume = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsk_setup_q <= '0;
			clock_setup_q <= '0;
			irq_mask_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FSK_SETUP: fsk_setup_q <= cfg_data;
				REG_CLOCK_SETUP: clock_setup_q <= cfg_data[4:0];
				REG_IRQ_MASK: irq_mask_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic [CNT_W-1:0] half;
		logic [CNT_W-1:0] rate;
		logic [CNT_W-1:0] p_inc;
		logic [CNT_W-1:0] c_inc;

		shift_word_d = shift_word_q;
		pulse_elapsed_d = pulse_elapsed_q;
		clock_elapsed_d = clock_elapsed_q;
		bits_sent_d = bits_sent_q;
		serial_level_d = serial_level_q;
		clock_level_d = clock_level_q;
		flag_bits_d = flag_bits_q;

		half = HALF_BASE << (shift_word_q[0] ? fsk_setup_q[2:0] : fsk_setup_q[5:3]);
		rate = rate_period(clock_setup_q[2:0]);
		p_inc = (pulse_elapsed_q == CNT_SAT) ? CNT_SAT : pulse_elapsed_q + 13'd1;
		c_inc = (clock_elapsed_q == CNT_SAT) ? CNT_SAT : clock_elapsed_q + 13'd1;

		case (item_s1.mode)
			MODE_TICK: begin
				pulse_elapsed_d = p_inc;
				if (fsk_setup_q[6] && p_inc >= half) begin
					serial_level_d = !serial_level_q;
					pulse_elapsed_d = p_inc & (half - 13'd1);
				end
				clock_elapsed_d = c_inc;
				if (clock_setup_q[4]) begin
					if (c_inc >= rate) begin
						clock_level_d = 1'b1;
						if (bits_sent_q < BITS_MAX) begin
							bits_sent_d = bits_sent_q + 4'd1;
						end
						if (bits_sent_d == BITS_DONE) begin
							flag_bits_d[3] = 1'b1;
						end
						shift_word_d = {1'b1, shift_word_q[15:1]};
						clock_elapsed_d = c_inc & (rate - 13'd1);
					end
					if (clock_level_d && clock_elapsed_d > rate_tenth(clock_setup_q[2:0])) begin
						clock_level_d = 1'b0;
					end
				end
			end
			MODE_LOAD: begin
				shift_word_d = {7'h7f, item_s1.data, 1'b0};
				bits_sent_d = '0;
				pulse_elapsed_d = '0;
				clock_elapsed_d = '0;
				flag_bits_d[3] = 1'b0;
			end
			MODE_FLAGS: begin
				flag_bits_d = item_s1.data[3:0];
			end
			default: ;
		endcase

		if (item_s1.irq_in) begin
			flag_bits_d[0] = 1'b1;
		end
		if (item_s1.pb7_in) begin
			flag_bits_d[1] = 1'b1;
		end
		intr = (irq_mask_q[0] && item_s1.irq_in) || (irq_mask_q[1] && item_s1.pb7_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_word_q <= SHIFT_RESET;
			pulse_elapsed_q <= '0;
			clock_elapsed_q <= '0;
			bits_sent_q <= '0;
			serial_level_q <= 1'b0;
			clock_level_q <= 1'b0;
			flag_bits_q <= '0;
		end else if (consume) begin
			shift_word_q <= shift_word_d;
			pulse_elapsed_q <= pulse_elapsed_d;
			clock_elapsed_q <= clock_elapsed_d;
			bits_sent_q <= bits_sent_d;
			serial_level_q <= serial_level_d;
			clock_level_q <= clock_level_d;
			flag_bits_q <= flag_bits_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (consume) begin
			out_q.serial_out <= serial_level_d;
			out_q.clock_out <= clock_level_d;
			out_q.interrupt <= intr;
			out_q.flags <= flag_bits_d;
		end
	end

`ifndef SYNTHESIS
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost or changed a stalled beat");

	a_consume_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		consume |=> out_valid_q)
		else $error("consumed beat did not reach the result register");

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		consume && item_s1.mode == MODE_LOAD |=>
		bits_sent_q == 4'd0 && clock_elapsed_q == '0 && pulse_elapsed_q == '0
		&& !flag_bits_q[3])
		else $error("byte load did not clear the transmit state");

	a_no_shift_when_off: assert property (@(posedge clk) disable iff (!arst_n)
		consume && item_s1.mode == MODE_TICK && !clock_setup_q[4] |=>
		$stable(shift_word_q) && $stable(bits_sent_q) && $stable(clock_level_q))
		else $error("shift happened with the clock output disabled");
`endif

endmodule
